@@ rtl/gfrp_pkg.sv @@
// Package for the growing first-fit rectangle packer.
// Holds sizes, the sequencer state type and the row memory request type; no dependencies.
`default_nettype none
package gfrp_pkg;
   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int RowBits    = MaxWidth;
   localparam int RowAddrW   = $clog2(MaxHeight);
   localparam int SideW      = $clog2(MaxWidth) + 1;
   localparam int PosW       = $clog2(MaxWidth);
   localparam int StepW      = 7;
   localparam logic [StepW-1:0] GrowStepReset = 7'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MERGE_RD, ST_MERGE, ST_SCAN, ST_GROW,
      ST_MARK_RD, ST_MARK_WR, ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic           we;
      logic [RowAddrW-1:0] addr;
      logic [RowBits-1:0]  wdata;
   } mem_req_type;
endpackage
`default_nettype wire

@@ rtl/gfrp_row_ram.sv @@
// Occupancy bitmap: one row per entry, synchronous (registered) read.
// Depends on gfrp_pkg. Cleared by a sweep after reset.
`default_nettype none
module gfrp_row_ram
   import gfrp_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_req_type       req,
   output      logic [RowBits-1:0] rdata
);
   logic [RowBits-1:0] mem [MaxHeight];

   // read-first single port: a write cycle returns the old row
   always_ff @(posedge clock) begin
      if (req.we) mem[req.addr] <= req.wdata;
      rdata <= mem[req.addr];
   end
endmodule
`default_nettype wire

@@ rtl/growing_first_fit_rect_packer_core.sv @@
// Growing first-fit rectangle packer: a window search over an occupancy row memory.
// Each request: a check state tests a band position, its rows are read (ST_MERGE_RD) and ORed
// (ST_MERGE) row by row, then columns are scanned one per cycle; area growth restarts the
// search, and a hit marks the band row by row with a read (ST_MARK_RD) and a write (ST_MARK_WR).
// After reset a clearing pass over every row zeroes the bitmap before the first beat is taken.
// Depends on gfrp_pkg and gfrp_row_ram.
`default_nettype none
module growing_first_fit_rect_packer_core
   import gfrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // rect_width[8:0], rect_height[17:9], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // place_x, place_y, area_width, area_height, status
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data     // grow_step[6:0]
);
   seq_state_type state_ff, state_in;
   logic [StepW-1:0]    step_ff;
   logic [SideW-1:0]    aw_ff, ah_ff, rw_ff, rh_ff;
   logic [SideW-1:0]    y_ff, r_ff, i_ff, run_ff;
   logic [PosW-1:0]     px_ff;
   logic [RowBits-1:0]  merged_ff;
   logic                clr_ff;
   logic [RowAddrW:0]   clr_cnt_ff;
   logic                rsp_v_ff;
   logic [39:0]         rsp_d_ff;
   mem_req_type         mreq;
   logic [RowBits-1:0]  rdata;

   gfrp_row_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !clr_ff && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   logic [SideW:0] y_end;
   assign y_end = {1'b0, y_ff} + {1'b0, rh_ff};

   // grow decision
   logic [SideW-1:0] step_v, g_w, g_h;
   logic [SideW:0]   sw, sh;
   logic             can_grow;
   always_comb begin
      step_v = (step_ff == '0) ? SideW'(1) : SideW'(step_ff);
      sw = {1'b0, aw_ff} + {1'b0, step_v};
      sh = {1'b0, ah_ff} + {1'b0, step_v};
      g_w = (sw > (SideW+1)'(MaxWidth))  ? SideW'(MaxWidth)  : sw[SideW-1:0];
      g_h = (sh > (SideW+1)'(MaxHeight)) ? SideW'(MaxHeight) : sh[SideW-1:0];
      can_grow = (aw_ff < rw_ff) || (ah_ff < rh_ff) || (aw_ff < SideW'(MaxWidth)) ||
                 (ah_ff < SideW'(MaxHeight));
   end

   // mark mask for row
   logic [RowBits-1:0] mark_mask;
   always_comb begin
      for (int k = 0; k < RowBits; k++)
         mark_mask[k] = (k >= int'(px_ff)) && (k < int'(px_ff) + int'(rw_ff));
   end

   // next state
   logic fits, cell_used;
   assign fits = (rw_ff <= aw_ff) && (rh_ff <= ah_ff) && (y_end <= {1'b0, ah_ff});
   assign cell_used = merged_ff[i_ff[PosW-1:0]];
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid && req_tready) state_in = ST_CHECK;
         ST_CHECK:
            if (rw_ff > SideW'(MaxWidth) || rh_ff > SideW'(MaxHeight)) state_in = ST_DONE;
            else if (!fits) state_in = ST_GROW;
            else if (rw_ff == '0) state_in = ST_DONE;
            else if (rh_ff == '0) state_in = ST_SCAN;
            else state_in = ST_MERGE_RD;
         ST_MERGE_RD: state_in = ST_MERGE;
         ST_MERGE:    if (r_ff + 1'b1 == rh_ff) state_in = ST_SCAN; else state_in = ST_MERGE_RD;
         ST_SCAN:
            if (!cell_used && run_ff + 1'b1 == rw_ff)
               state_in = (rh_ff == '0) ? ST_DONE : ST_MARK_RD;
            else if (i_ff + 1'b1 >= aw_ff) state_in = ST_CHECK;
         ST_GROW:     state_in = can_grow ? ST_CHECK : ST_DONE;
         ST_MARK_RD:  state_in = ST_MARK_WR;
         ST_MARK_WR:  if (r_ff + 1'b1 == rh_ff) state_in = ST_DONE; else state_in = ST_MARK_RD;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory port
   always_comb begin
      mreq.we    = 1'b0;
      mreq.addr  = RowAddrW'(y_ff + r_ff);
      mreq.wdata = rdata | mark_mask;
      if (clr_ff) begin
         mreq.we    = 1'b1;
         mreq.addr  = clr_cnt_ff[RowAddrW-1:0];
         mreq.wdata = '0;
      end else if (state_ff == ST_MARK_WR) begin
         mreq.we = 1'b1;
      end
   end

   logic status_ff;
   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= GrowStepReset;
         aw_ff      <= SideW'(1);
         ah_ff      <= SideW'(1);
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) step_ff <= csr_data[StepW-1:0];
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (RowAddrW+1)'(MaxHeight - 1)) clr_ff <= 1'b0;
         end
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               rw_ff <= req_tdata[8:0];
               rh_ff <= req_tdata[17:9];
               y_ff <= '0; px_ff <= '0; status_ff <= 1'b1;
               r_ff <= '0; i_ff <= '0; run_ff <= '0; merged_ff <= '0;
            end
            ST_CHECK: begin
               r_ff <= '0; i_ff <= '0; run_ff <= '0; merged_ff <= '0;
               if (fits && rw_ff == '0 && rw_ff <= SideW'(MaxWidth)
                   && rh_ff <= SideW'(MaxHeight)) begin
                  px_ff <= '0; status_ff <= 1'b0;
               end
            end
            ST_MERGE: begin
               merged_ff <= merged_ff | rdata;
               r_ff <= r_ff + 1'b1;
            end
            ST_SCAN: begin
               if (!cell_used && run_ff + 1'b1 == rw_ff) begin
                  px_ff <= PosW'(i_ff + 1'b1 - rw_ff);
                  status_ff <= 1'b0;
                  r_ff <= '0;
               end else if (i_ff + 1'b1 >= aw_ff) begin
                  y_ff <= y_ff + 1'b1;
               end
               run_ff <= cell_used ? '0 : run_ff + 1'b1;
               i_ff <= i_ff + 1'b1;
            end
            ST_GROW: begin
               y_ff <= '0;
               if (aw_ff < rw_ff) aw_ff <= rw_ff;
               else if (ah_ff < rh_ff) ah_ff <= rh_ff;
               else if (aw_ff <= ah_ff && aw_ff < SideW'(MaxWidth)) aw_ff <= g_w;
               else if (aw_ff > ah_ff && ah_ff < SideW'(MaxHeight)) ah_ff <= g_h;
               else if (aw_ff < SideW'(MaxWidth)) aw_ff <= g_w;
               else if (ah_ff < SideW'(MaxHeight)) ah_ff <= g_h;
            end
            ST_MARK_WR: r_ff <= r_ff + 1'b1;
            ST_DONE: begin
               rsp_v_ff <= 1'b1;
               rsp_d_ff <= {5'd0, status_ff, ah_ff, aw_ff,
                            status_ff ? 8'd0 : y_ff[7:0], status_ff ? 8'd0 : px_ff};
            end
            default: ;
         endcase
      end
   end

   // checks
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_tready) else $error("accept during clear");
   a_area_min: assert property (@(posedge clock) disable iff (reset)
      (aw_ff != '0) && (ah_ff != '0)) else $error("area zero");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");
   a_area_max: assert property (@(posedge clock) disable iff (reset)
      aw_ff <= SideW'(MaxWidth) && ah_ff <= SideW'(MaxHeight)) else $error("area over max");
endmodule
`default_nettype wire
